[rtl/tteh_pkg.sv]
// Package: shared types, codes and constants of the TCP timer expiry handler.
`timescale 1ns / 1ps

package tteh_pkg;

    localparam int unsigned TICK_W   = 16;
    localparam int unsigned BK_W     = 4;
    localparam int unsigned STATE_W  = 4;
    localparam int unsigned SSTH_W   = 17;
    localparam int unsigned W2_W     = 15;
    localparam int unsigned SCALE_W  = 7;
    localparam int unsigned RX_W     = TICK_W + SCALE_W;
    localparam int unsigned CFG_IDX_W = 3;

    // Expired timer codes.
    typedef enum logic [1:0] {
        TMR_REXMT   = 2'd0,
        TMR_PERSIST = 2'd1,
        TMR_KEEP    = 2'd2,
        TMR_2MSL    = 2'd3
    } t_timer;

    // Verdict codes returned with each result word.
    typedef enum logic [2:0] {
        V_2MSL_RECHECK = 3'd0,
        V_DESTROY      = 3'd1,
        V_REXMT_DROP   = 3'd2,
        V_RETRANSMIT   = 3'd3,
        V_PERSIST_SEND = 3'd4,
        V_KEEP_REARM   = 3'd5,
        V_KEEP_DROP    = 3'd6
    } t_verdict;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_REXMT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REXMT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_IDLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP      = 3'd3;

    localparam logic [TICK_W-1:0] MIN_REXMT_RST = 16'd2;
    localparam logic [TICK_W-1:0] MAX_REXMT_RST = 16'd128;
    localparam logic [TICK_W-1:0] MAX_IDLE_RST  = 16'd720;
    localparam logic [TICK_W-1:0] KEEP_RST      = 16'd90;

    // Connection states, BSD numbering.
    localparam logic [STATE_W-1:0] ST_ESTABLISHED = 4'd4;
    localparam logic [STATE_W-1:0] ST_TIME_WAIT   = 4'd10;

    localparam int unsigned MIN_SSTHRESH_SEGS = 2;

    // Retransmit backoff multipliers.
    localparam int unsigned TABLE_LEN = 13;
    localparam logic [SCALE_W-1:0] BACKOFF_SCALE [TABLE_LEN] = '{
        7'd1, 7'd2, 7'd4, 7'd8, 7'd16, 7'd32, 7'd64,
        7'd64, 7'd64, 7'd64, 7'd64, 7'd64, 7'd64
    };

    typedef struct packed {
        t_timer               which_timer;
        logic [STATE_W-1:0]   conn_state;
        logic [TICK_W-1:0]    idle_ticks;
        logic [BK_W-1:0]      backoff_count;
        logic [TICK_W-1:0]    smoothed_rtt;
        logic [TICK_W-1:0]    rtt_variance;
        logic [TICK_W-1:0]    send_window;
        logic [TICK_W-1:0]    congestion_window;
        logic [TICK_W-1:0]    max_segment;
    } t_req_word;

    typedef struct packed {
        t_verdict             verdict;
        logic [TICK_W-1:0]    timer_reload;
        logic [BK_W-1:0]      new_backoff_count;
        logic [TICK_W-1:0]    new_smoothed_rtt;
        logic [TICK_W-1:0]    new_rtt_variance;
        logic [TICK_W-1:0]    new_congestion_window;
        logic [SSTH_W-1:0]    new_slow_start_threshold;
        logic                 ssthresh_valid;
        logic                 rewind_and_stop_rtt;
    } t_rsp_word;

    // Word carried through the inner pipeline stages.
    typedef struct packed {
        t_verdict             verdict;
        logic [TICK_W-1:0]    reload;
        logic [BK_W-1:0]      nbk;
        logic [TICK_W-1:0]    srtt;
        logic [TICK_W-1:0]    rvar;
        logic [TICK_W-1:0]    cwnd;
        logic [TICK_W-1:0]    mss;
        logic [W2_W-1:0]      w2;
        logic [SCALE_W-1:0]   scale;
        logic [TICK_W-1:0]    base;
        logic [RX_W-1:0]      rx;
        logic [TICK_W-1:0]    rem;
        logic [W2_W-1:0]      quo;
    } t_pipe;

endpackage

[rtl/tteh_req_if.sv]
// Interface: request channel carrying one expired-timer word.
`timescale 1ns / 1ps

interface tteh_req_if;
    logic               valid;
    logic               ready;
    tteh_pkg::t_req_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/tteh_rsp_if.sv]
// Interface: response channel carrying one verdict word.
`timescale 1ns / 1ps

interface tteh_rsp_if;
    logic               valid;
    logic               ready;
    tteh_pkg::t_rsp_word payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

[rtl/tteh_div_step.sv]
// Module: a few restoring division steps, one quotient bit per step.
`timescale 1ns / 1ps

module tteh_div_step #(
    parameter int HI    = 14,
    parameter int STEPS = 4
) (
    input  logic [tteh_pkg::W2_W-1:0]   i_dvd,
    input  logic [tteh_pkg::TICK_W-1:0] i_dsr,
    input  logic [tteh_pkg::TICK_W-1:0] i_rem,
    input  logic [tteh_pkg::W2_W-1:0]   i_quo,
    output logic [tteh_pkg::TICK_W-1:0] o_rem,
    output logic [tteh_pkg::W2_W-1:0]   o_quo
);
    import tteh_pkg::*;

    always_comb begin
        logic [TICK_W:0]   trial;
        logic [TICK_W-1:0] rem;
        logic [W2_W-1:0]   quo;
        rem = i_rem;
        quo = i_quo;
        for (int k = 0; k < STEPS; k++) begin
            trial = {rem, i_dvd[HI-k]};
            if (trial >= {1'b0, i_dsr}) begin
                trial      = trial - {1'b0, i_dsr};
                quo[HI-k]  = 1'b1;
            end
            rem = trial[TICK_W-1:0];
        end
        o_rem = rem;
        o_quo = quo;
    end

endmodule

[rtl/tcp_timer_expiry_handler_core.sv]
// Top level: TCP timer expiry handler with retransmit backoff, six-stage pipeline.
`timescale 1ns / 1ps

//  Channel   Dir  Handshake          Word
//  i_req     in   valid/ready        expired timer code and connection fields
//  o_rsp     out  valid/ready        verdict and updated connection values
//  i_cfg_*   in   write enable only  min/max retransmit clamp, idle limit, keep reload
//
// One word is accepted per cycle unless the pipeline is full and o_rsp is stalled,
// and it passes through six register stages. The depth is set by the
// window-by-segment division, which retires four quotient bits in each of stages
// three to five and the last three bits in stage six.
// Reset is synchronous and active low; it empties the pipeline and loads the
// register defaults. A stalled output holds its word, and each stage keeps taking
// words as long as a stage ahead of it is empty, so bubbles close up under stall.

module tcp_timer_expiry_handler_core #(
    parameter int MAX_BACKOFF = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    tteh_req_if.sink                       i_req,
    tteh_rsp_if.source                     o_rsp,
    input  logic                           i_cfg_we,
    input  logic [tteh_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tteh_pkg::TICK_W-1:0]    i_cfg_data
);
    import tteh_pkg::*;

    localparam int unsigned NSTG = 6;
    localparam logic [BK_W:0] MAX_BK   = (BK_W+1)'(MAX_BACKOFF);
    localparam logic [BK_W:0] CLOB_LIM = (BK_W+1)'(MAX_BACKOFF / 4);
    localparam logic [BK_W:0] TAB_LEN  = (BK_W+1)'(TABLE_LEN);

    // Configuration registers.
    logic [TICK_W-1:0] r_min_rexmt;
    logic [TICK_W-1:0] r_max_rexmt;
    logic [TICK_W-1:0] r_max_idle;
    logic [TICK_W-1:0] r_keep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rexmt <= MIN_REXMT_RST;
            r_max_rexmt <= MAX_REXMT_RST;
            r_max_idle  <= MAX_IDLE_RST;
            r_keep      <= KEEP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MIN_REXMT: r_min_rexmt <= i_cfg_data;
                REG_MAX_REXMT: r_max_rexmt <= i_cfg_data;
                REG_MAX_IDLE:  r_max_idle  <= i_cfg_data;
                REG_KEEP:      r_keep      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage valid bits and the ready chain. A stage takes a new word when it is
    // empty or when its own word moves on in the same cycle.
    logic [NSTG:1] r_vld;
    logic [NSTG:1] stg_rdy;

    always_comb begin
        stg_rdy[NSTG] = !r_vld[NSTG] || o_rsp.ready;
        for (int s = NSTG - 1; s >= 1; s--) begin
            stg_rdy[s] = !r_vld[s] || stg_rdy[s+1];
        end
    end

    assign i_req.ready = stg_rdy[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[1]) begin
                r_vld[1] <= i_req.valid;
            end
            for (int s = 2; s <= NSTG; s++) begin
                if (stg_rdy[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Stage 1: capture the request word.
    t_req_word r_s1;

    always_ff @(posedge i_clk) begin
        if (stg_rdy[1]) begin
            r_s1 <= i_req.payload;
        end
    end

    // Stage 2: decode the timer, back off the retransmit count, form the
    // timeout base, the clobbered variance and the halved window.
    t_pipe r_s2, n_s2;

    always_comb begin
        logic [BK_W:0]     ns;
        logic [BK_W-1:0]   idx;
        logic [TICK_W:0]   sum;
        logic [TICK_W-1:0] win;
        ns  = {1'b0, r_s1.backoff_count} + (BK_W+1)'(1);
        idx = (ns < TAB_LEN) ? ns[BK_W-1:0] : BK_W'(TABLE_LEN - 1);
        sum = {3'b000, r_s1.smoothed_rtt[TICK_W-1:2]} + {1'b0, r_s1.rtt_variance};
        win = (r_s1.send_window < r_s1.congestion_window) ?
              r_s1.send_window : r_s1.congestion_window;

        n_s2        = '0;
        n_s2.nbk    = r_s1.backoff_count;
        n_s2.srtt   = r_s1.smoothed_rtt;
        n_s2.rvar   = r_s1.rtt_variance;
        n_s2.cwnd   = r_s1.congestion_window;
        n_s2.mss    = r_s1.max_segment;
        n_s2.w2     = win[TICK_W-1:1];
        n_s2.scale  = BACKOFF_SCALE[idx];
        n_s2.base   = sum[TICK_W:1];

        case (r_s1.which_timer)
            TMR_REXMT: begin
                if (ns > MAX_BK) begin
                    n_s2.verdict = V_REXMT_DROP;
                    n_s2.nbk     = MAX_BK[BK_W-1:0];
                end else begin
                    n_s2.verdict = V_RETRANSMIT;
                    n_s2.nbk     = ns[BK_W-1:0];
                    n_s2.cwnd    = r_s1.max_segment;
                    // After enough backoffs the RTT estimate is distrusted:
                    // fold a quarter of srtt into the variance and clear srtt.
                    if (ns > CLOB_LIM) begin
                        n_s2.rvar = sum[TICK_W] ? '1 : sum[TICK_W-1:0];
                        n_s2.srtt = '0;
                    end
                end
            end
            TMR_PERSIST: begin
                n_s2.verdict = V_PERSIST_SEND;
            end
            TMR_KEEP: begin
                if (r_s1.conn_state < ST_ESTABLISHED) begin
                    n_s2.verdict = V_KEEP_DROP;
                end else begin
                    n_s2.verdict = V_KEEP_REARM;
                    n_s2.reload  = r_keep;
                end
            end
            default: begin
                if (r_s1.conn_state != ST_TIME_WAIT && r_s1.idle_ticks <= r_max_idle) begin
                    n_s2.verdict = V_2MSL_RECHECK;
                    n_s2.reload  = r_keep;
                end else begin
                    n_s2.verdict = V_DESTROY;
                end
            end
        endcase
    end

    // Stage 3: scale the timeout; first four quotient bits of window/2 by mss.
    t_pipe r_s3, n_s3;
    logic [TICK_W-1:0] div3_rem;
    logic [W2_W-1:0]   div3_quo;

    tteh_div_step #(.HI(14), .STEPS(4)) u_div3 (
        .i_dvd (r_s2.w2),
        .i_dsr (r_s2.mss),
        .i_rem ('0),
        .i_quo ('0),
        .o_rem (div3_rem),
        .o_quo (div3_quo)
    );

    always_comb begin
        n_s3     = r_s2;
        n_s3.rx  = RX_W'(r_s2.base) * RX_W'(r_s2.scale);
        n_s3.rem = div3_rem;
        n_s3.quo = div3_quo;
    end

    // Stage 4: clamp the timeout, the minimum winning over the maximum; next four quotient bits.
    t_pipe r_s4, n_s4;
    logic [TICK_W-1:0] div4_rem;
    logic [W2_W-1:0]   div4_quo;

    tteh_div_step #(.HI(10), .STEPS(4)) u_div4 (
        .i_dvd (r_s3.w2),
        .i_dsr (r_s3.mss),
        .i_rem (r_s3.rem),
        .i_quo (r_s3.quo),
        .o_rem (div4_rem),
        .o_quo (div4_quo)
    );

    always_comb begin
        n_s4     = r_s3;
        n_s4.rem = div4_rem;
        n_s4.quo = div4_quo;
        if (r_s3.verdict == V_RETRANSMIT) begin
            if (r_s3.rx < {{SCALE_W{1'b0}}, r_min_rexmt}) begin
                n_s4.reload = r_min_rexmt;
            end else if (r_s3.rx > {{SCALE_W{1'b0}}, r_max_rexmt}) begin
                n_s4.reload = r_max_rexmt;
            end else begin
                n_s4.reload = r_s3.rx[TICK_W-1:0];
            end
        end
    end

    // Stage 5: next four quotient bits.
    t_pipe r_s5, n_s5;
    logic [TICK_W-1:0] div5_rem;
    logic [W2_W-1:0]   div5_quo;

    tteh_div_step #(.HI(6), .STEPS(4)) u_div5 (
        .i_dvd (r_s4.w2),
        .i_dsr (r_s4.mss),
        .i_rem (r_s4.rem),
        .i_quo (r_s4.quo),
        .o_rem (div5_rem),
        .o_quo (div5_quo)
    );

    always_comb begin
        n_s5     = r_s4;
        n_s5.rem = div5_rem;
        n_s5.quo = div5_quo;
    end

    // Stage 6: last three quotient bits and the slow start threshold. Since
    // quotient times mss equals the halved window less the remainder, no
    // multiplier is needed; below two segments the threshold is two segments.
    t_rsp_word r_s6, n_s6;
    logic [TICK_W-1:0] div6_rem;
    logic [W2_W-1:0]   div6_quo;

    tteh_div_step #(.HI(2), .STEPS(3)) u_div6 (
        .i_dvd (r_s5.w2),
        .i_dsr (r_s5.mss),
        .i_rem (r_s5.rem),
        .i_quo (r_s5.quo),
        .o_rem (div6_rem),
        .o_quo (div6_quo)
    );

    always_comb begin
        logic is_rx;
        is_rx = (r_s5.verdict == V_RETRANSMIT);

        n_s6.verdict               = r_s5.verdict;
        n_s6.timer_reload          = r_s5.reload;
        n_s6.new_backoff_count     = r_s5.nbk;
        n_s6.new_smoothed_rtt      = r_s5.srtt;
        n_s6.new_rtt_variance      = r_s5.rvar;
        n_s6.new_congestion_window = r_s5.cwnd;
        n_s6.ssthresh_valid        = is_rx;
        n_s6.rewind_and_stop_rtt   = is_rx;
        n_s6.new_slow_start_threshold = '0;
        if (is_rx && r_s5.mss != '0) begin
            if (div6_quo >= W2_W'(MIN_SSTHRESH_SEGS)) begin
                n_s6.new_slow_start_threshold =
                    SSTH_W'({1'b0, r_s5.w2}) - SSTH_W'(div6_rem);
            end else begin
                n_s6.new_slow_start_threshold = {r_s5.mss, 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stg_rdy[2]) begin
            r_s2 <= n_s2;
        end
        if (stg_rdy[3]) begin
            r_s3 <= n_s3;
        end
        if (stg_rdy[4]) begin
            r_s4 <= n_s4;
        end
        if (stg_rdy[5]) begin
            r_s5 <= n_s5;
        end
        if (stg_rdy[6]) begin
            r_s6 <= n_s6;
        end
    end

    assign o_rsp.valid   = r_vld[NSTG];
    assign o_rsp.payload = r_s6;

endmodule
